/* design/pwmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pwmc_pkg;

  // timer clock numerator and limits
  localparam logic [29:0] ClkNum    = 30'd640000000;
  localparam logic [28:0] FreqMax   = 29'd320000000;
  localparam logic [13:0] DutyMax   = 14'd10000;
  localparam logic [15:0] PeriodMax = 16'hFFFF;
  localparam logic [29:0] DutyHalf  = 30'd5000;

  // quotient may be at most PeriodMax + 1 before the minus one
  localparam logic [29:0] NormLimit = 30'd65536;

  // x / 10000 == (x * RecipM) >> RecipShift for every x below 2^30
  localparam logic [29:0] RecipM     = 30'd879609303;
  localparam int unsigned RecipShift = 43;

  localparam int unsigned DivSteps = 30;
  localparam logic [4:0]  DivLast  = 5'(DivSteps - 1);
  localparam logic [3:0]  PreMax   = 4'd15;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActStopped = 2'd1,
    ActStarted = 2'd2,
    ActUpdated = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StNorm,
    StMul1,
    StMul2,
    StFin
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic norm_step;
    logic mul1;
    logic mul2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic short_path;
    logic div_last;
    logic norm_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* design/pwmc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwmc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pwmc_pkg::status_t status_i,
  output pwmc_pkg::cmd_t        cmd_o
);

  pwmc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwmc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwmc_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = pwmc_pkg::StDiv;
        end
      end
      pwmc_pkg::StDiv: begin
        // stop requests and requests for a channel that does not exist skip the arithmetic
        if (status_i.short_path) begin
          state_d = pwmc_pkg::StFin;
        end else if (status_i.div_last) begin
          state_d = pwmc_pkg::StNorm;
        end
      end
      pwmc_pkg::StNorm: begin
        if (status_i.norm_done) begin
          state_d = pwmc_pkg::StMul1;
        end
      end
      pwmc_pkg::StMul1: state_d = pwmc_pkg::StMul2;
      pwmc_pkg::StMul2: state_d = pwmc_pkg::StFin;
      pwmc_pkg::StFin: begin
        if (status_i.out_free) begin
          state_d = pwmc_pkg::StIdle;
        end
      end
      default: state_d = pwmc_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pwmc_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      pwmc_pkg::StDiv:  cmd_o.div_step  = !status_i.short_path;
      pwmc_pkg::StNorm: cmd_o.norm_step = !status_i.norm_done;
      pwmc_pkg::StMul1: cmd_o.mul1      = 1'b1;
      pwmc_pkg::StMul2: cmd_o.mul2      = 1'b1;
      pwmc_pkg::StFin:  cmd_o.out_load  = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/pwmc_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwmc_dpath #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        chan_i,
  input  wire logic [28:0]       freq_hz_i,
  input  wire logic [13:0]       duty_i,
  input  wire pwmc_pkg::cmd_t    cmd_i,
  output pwmc_pkg::status_t      status_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             chan_out_o,
  output logic [1:0]             action_o,
  output logic [3:0]             prescale_exp_o,
  output logic [15:0]            period_count_o,
  output logic [15:0]            compare_count_o
);

  logic [NUM_CHANNELS-1:0] active_q;
  logic                    short_q;
  logic [1:0]              chan_q;
  pwmc_pkg::act_e          act_q;
  logic [28:0]             freq_q;
  logic [13:0]             duty_q;
  logic [28:0]             rem_q;
  logic [29:0]             quo_q;
  logic [4:0]              cnt_q;
  logic [3:0]              pre_q;
  logic [15:0]             per_q;
  logic [29:0]             prod_q;
  logic [59:0]             scaled_q;
  logic                    out_valid_q;

  logic                    chan_ok;
  logic                    cur_active;
  logic [29:0]             trial;
  logic                    fits;
  logic [15:0]             per_d;

  // channel decode, one compare per channel
  always_comb begin
    chan_ok    = 1'b0;
    cur_active = 1'b0;
    for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
      if (32'(chan_i) == i) begin
        chan_ok    = 1'b1;
        cur_active = active_q[i];
      end
    end
  end

  assign trial = {rem_q, quo_q[29]};
  assign fits  = trial >= {1'b0, freq_q};
  assign per_d = 16'(quo_q - 30'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.load && chan_ok) begin
      for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
        if (32'(chan_i) == i) begin
          active_q[i] <= (freq_hz_i != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      chan_q  <= chan_i;
      short_q <= !chan_ok || (freq_hz_i == '0);
      if (!chan_ok) begin
        act_q <= pwmc_pkg::ActNone;
      end else if (freq_hz_i == '0) begin
        act_q <= cur_active ? pwmc_pkg::ActStopped : pwmc_pkg::ActNone;
      end else begin
        act_q <= cur_active ? pwmc_pkg::ActUpdated : pwmc_pkg::ActStarted;
      end
      freq_q <= (freq_hz_i > pwmc_pkg::FreqMax) ? pwmc_pkg::FreqMax : freq_hz_i;
      duty_q <= (duty_i > pwmc_pkg::DutyMax) ? pwmc_pkg::DutyMax : duty_i;
      rem_q  <= '0;
      quo_q  <= pwmc_pkg::ClkNum;
      cnt_q  <= '0;
      pre_q  <= '0;
    end else if (cmd_i.div_step) begin
      // restoring divide, one quotient bit a cycle
      rem_q <= fits ? 29'(trial - {1'b0, freq_q}) : trial[28:0];
      quo_q <= {quo_q[28:0], fits};
      cnt_q <= cnt_q + 5'd1;
    end else if (cmd_i.norm_step) begin
      quo_q <= {1'b0, quo_q[29:1]};
      pre_q <= pre_q + 4'd1;
    end
    if (cmd_i.mul1) begin
      per_q  <= per_d;
      prod_q <= 30'(per_d) * 30'(duty_q);
    end
    if (cmd_i.mul2) begin
      scaled_q <= 60'(prod_q + pwmc_pkg::DutyHalf) * 60'(pwmc_pkg::RecipM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      chan_out_o <= chan_q;
      action_o   <= act_q;
      if (short_q) begin
        prescale_exp_o  <= '0;
        period_count_o  <= '0;
        compare_count_o <= '0;
      end else begin
        prescale_exp_o  <= pre_q;
        period_count_o  <= per_q;
        compare_count_o <= scaled_q[pwmc_pkg::RecipShift +: 16];
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o.short_path  = short_q;
  assign status_o.div_last    = (cnt_q == pwmc_pkg::DivLast);
  assign status_o.norm_done   = (quo_q <= pwmc_pkg::NormLimit);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending word");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_pre_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.norm_step |-> (pre_q < pwmc_pkg::PreMax))
    else $error("prescaler exponent overflow");

  a_quo_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && status_o.div_last) |=> (quo_q >= 30'd2))
    else $error("quotient below two");

endmodule

`default_nettype wire

/* design/pwm_timer_setting_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

// PWM timer setting calculator: each input word names a channel, a frequency
// in Hz and a duty in hundredths of a percent, and exactly one result word
// comes back with the action taken, the prescaler exponent, the period and
// the compare value. A run request passes from acceptance to result through
// the bit-serial divider for 640000000/f, one prescaler step (0 to 14) at a
// time while the quotient is shifted down into 16 bits, a check that sees it
// fit, two multiply steps for the duty scaling and the divide by 10000, and
// a final step that loads the result register once it is free.
// Stop requests and requests for a channel that does not exist skip the arithmetic.
// One request is worked on at a time; the result register lets the next
// request be accepted while the previous result is still waiting.
module pwm_timer_setting_calc #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request word
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  chan_i,
  input  wire logic [28:0] freq_hz_i,
  input  wire logic [13:0] duty_i,
  // result word
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       chan_out_o,
  output logic [1:0]       action_o,
  output logic [3:0]       prescale_exp_o,
  output logic [15:0]      period_count_o,
  output logic [15:0]      compare_count_o
);

  // command and status between sequencer and datapath
  pwmc_pkg::cmd_t    cmd;
  pwmc_pkg::status_t status;

  // sequencer: idle, divide, normalize, two multiplies, deliver
  pwmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // divider, prescaler search, multipliers, channel flags and result register
  pwmc_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .chan_i          (chan_i),
    .freq_hz_i       (freq_hz_i),
    .duty_i          (duty_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .chan_out_o      (chan_out_o),
    .action_o        (action_o),
    .prescale_exp_o  (prescale_exp_o),
    .period_count_o  (period_count_o),
    .compare_count_o (compare_count_o)
  );

endmodule

`default_nettype wire

/* tb/tb_pwm_timer_setting_calc.sv */
`timescale 1ns / 1ps

// request words go in through a queue filled up front; the driver takes them in bursts,
// works out the expected timer settings for every accepted word and the monitor checks
// each returned word against the oldest one still due
module tb_pwm_timer_setting_calc;

  localparam int unsigned NUM_CH       = 4;
  localparam int unsigned RANDOM_WORDS = 1730;

  // frequencies on either side of a prescaler step, plus the extremes
  localparam logic [28:0] BOUNDARY_FREQS [8] = '{
    29'd1, 29'd2, 29'd4882, 29'd4883, 29'd9765, 29'd9766, 29'd319999999, 29'd320000000
  };

  typedef struct packed {
    logic [1:0]  chan;
    logic [28:0] freq;
    logic [13:0] duty;
  } request_t;

  typedef struct packed {
    logic [1:0]     chan;
    pwmc_pkg::act_e act;
    logic [3:0]     pre;
    logic [15:0]    per;
    logic [15:0]    cmp;
  } settings_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  chan_i      = '0;
  logic [28:0] freq_hz_i   = '0;
  logic [13:0] duty_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  chan_out_o;
  logic [1:0]  action_o;
  logic [3:0]  prescale_exp_o;
  logic [15:0] period_count_o;
  logic [15:0] compare_count_o;

  request_t    pending_requests [$];
  settings_t   settings_due [$];
  logic        chan_running [NUM_CH];
  int unsigned fail_count = 0;

  pwm_timer_setting_calc #(
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .chan_i         (chan_i),
    .freq_hz_i      (freq_hz_i),
    .duty_i         (duty_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chan_out_o     (chan_out_o),
    .action_o       (action_o),
    .prescale_exp_o (prescale_exp_o),
    .period_count_o (period_count_o),
    .compare_count_o(compare_count_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[pwm_timer_setting_calc] ERROR");
    $finish;
  end

  // timer settings for one request, advancing the per-channel running flags
  function automatic settings_t timer_settings_for(input request_t r);
    settings_t   s;
    logic [63:0] f;
    logic [63:0] d;
    logic [63:0] per;
    logic [63:0] cmp;
    int unsigned p;
    s      = '0;
    s.chan = r.chan;
    s.act  = pwmc_pkg::ActNone;
    if (r.chan >= NUM_CH) return s;
    if (r.freq == 0) begin
      // stop: only a running channel reports it
      if (chan_running[r.chan]) s.act = pwmc_pkg::ActStopped;
      chan_running[r.chan] = 1'b0;
      return s;
    end
    f = (r.freq > pwmc_pkg::FreqMax) ? 64'(pwmc_pkg::FreqMax) : 64'(r.freq);
    d = (r.duty > pwmc_pkg::DutyMax) ? 64'(pwmc_pkg::DutyMax) : 64'(r.duty);
    s.act = chan_running[r.chan] ? pwmc_pkg::ActUpdated : pwmc_pkg::ActStarted;
    chan_running[r.chan] = 1'b1;
    // smallest exponent that brings the period into 16 bits
    p   = 0;
    per = 64'(pwmc_pkg::ClkNum) / f - 1;
    while (per > 64'(pwmc_pkg::PeriodMax) && p < 15) begin
      p++;
      per = 64'(pwmc_pkg::ClkNum) / (f << p) - 1;
    end
    cmp   = (per * d + 64'(pwmc_pkg::DutyHalf)) / 64'(pwmc_pkg::DutyMax);
    s.pre = 4'(p);
    s.per = per[15:0];
    s.cmp = cmp[15:0];
    return s;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  task automatic add_request(input logic [1:0] c, input logic [28:0] f, input logic [13:0] d);
    request_t r;
    r.chan = c;
    r.freq = f;
    r.duty = d;
    pending_requests.push_back(r);
  endtask

  // stimulus and end of run
  initial begin : run
    logic [28:0] f;
    logic [13:0] d;
    int unsigned width;
    // directed words: extremes, saturation, each action and prescaler edges
    add_request(2'd0, 29'd1, 14'd10000);
    add_request(2'd0, pwmc_pkg::FreqMax, 14'd0);
    add_request(2'd0, 29'h1FFFFFFF, 14'h3FFF);
    add_request(2'd0, 29'd0, 14'd5000);
    add_request(2'd0, 29'd0, 14'd0);
    add_request(2'd1, 29'd9766, 14'd5000);
    add_request(2'd1, 29'd9765, 14'd5000);
    add_request(2'd1, 29'd4883, 14'd1);
    add_request(2'd1, 29'd4882, 14'd9999);
    add_request(2'd2, 29'(pwmc_pkg::FreqMax + 1), 14'd10001);
    add_request(2'd2, 29'd1000, 14'h3FFF);
    add_request(2'd3, 29'd0, 14'h3FFF);
    add_request(2'd3, 29'd50, 14'd2500);
    add_request(2'd3, 29'd0, 14'd0);
    add_request(2'd1, 29'd0, 14'd0);
    add_request(2'd2, 29'd0, 14'd0);
    add_request(2'd3, 29'd1, 14'd0);
    add_request(2'd0, 29'd2, 14'd10000);
    add_request(2'd0, 29'd160000000, 14'd5000);
    add_request(2'd2, 29'h0AAAAAAA, 14'h2AAA);
    add_request(2'd2, 29'h15555555, 14'h1555);

    repeat (RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1: f = '0;
        2: f = 29'($urandom());
        3: f = BOUNDARY_FREQS[$urandom_range(0, 7)] + 29'($urandom_range(0, 2)) - 29'd1;
        default: begin
          // spread over all magnitudes
          width = $urandom_range(1, 29);
          f = 29'($urandom() >> (32 - width));
          if (f == 0) f = 29'd1;
        end
      endcase
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = pwmc_pkg::DutyMax;
        2: d = 14'($urandom_range(0, 16383));
        default: d = 14'($urandom_range(0, 10000));
      endcase
      add_request(2'($urandom_range(0, 3)), f, d);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_requests.size() != 0 || in_valid_i || settings_due.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[pwm_timer_setting_calc] OK");
    end else begin
      $display("[pwm_timer_setting_calc] ERROR");
    end
    $finish;
  end

  // driver: bursts of request words with random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin : drive
    request_t    r;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      chan_i     <= '0;
      freq_hz_i  <= '0;
      duty_i     <= '0;
      burst_left = 1;
      gap_left   = 0;
      for (int i = 0; i < NUM_CH; i++) chan_running[i] = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        r.chan = chan_i;
        r.freq = freq_hz_i;
        r.duty = duty_i;
        settings_due.push_back(timer_settings_for(r));
      end
      // payload may only change once the current word is gone
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          r = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          chan_i     <= r.chan;
          freq_hz_i  <= r.freq;
          duty_i     <= r.duty;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes, plus two long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin : receive
    int unsigned words_taken;
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    logic        rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      words_taken = 0;
      hold_left   = 0;
      mode        = 0;
      mode_left   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        words_taken++;
        // block fills up while the driver keeps offering
        if (words_taken == 200 || words_taken == 1000) hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = mode_left[0];
      endcase
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_ready_i <= rdy;
    end
  end

  // monitor: each accepted result word against the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin : watch
    settings_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (settings_due.size() == 0) begin
        $display("%0t unexpected word: chan %0d action %0d exp %0d period %0d compare %0d",
                 $time, chan_out_o, action_o, prescale_exp_o, period_count_o,
                 compare_count_o);
        fail_count++;
      end else begin
        want = settings_due.pop_front();
        check_field("chan_out", want.chan, chan_out_o);
        check_field("action", want.act, action_o);
        check_field("prescale_exp", want.pre, prescale_exp_o);
        check_field("period_count", want.per, period_count_o);
        check_field("compare_count", want.cmp, compare_count_o);
      end
    end
  end

endmodule
